// ===== sv/cpe_pkg.sv =====
package cpe_pkg;

  // Angle word inside the CORDIC units: 30 fraction bits, room for +-(pi + gain).
  typedef logic signed [34:0] ang_t;
  // sin and cos with 16 fraction bits.
  typedef logic signed [17:0] trig_t;
  // Matrix entries and atan2 operands with 16 fraction bits.
  typedef logic signed [18:0] mtx_t;

  localparam ang_t ANG_PI      = 35'sd3373259426;
  localparam ang_t ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // Width of the square-root radicand and the number of root digits.
  localparam int SQ_W     = 36;
  localparam int SQ_STEPS = 18;
  localparam int ROOT_W   = 18;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_EAST  = 2'd0;
  localparam logic [1:0] REG_START_NORTH = 2'd1;

  // atan(2^-i) scaled by 2^30, rounded to nearest.
  localparam logic [30:0] ATAN_TAB [25] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128,
    31'd64
  };

  // Rotation-matrix entries that travel together.
  typedef struct packed {
    mtx_t r00;
    mtx_t r10;
    mtx_t r20n;
    mtx_t r21;
    mtx_t r22;
  } rot_t;

  typedef struct packed {
    rot_t            rot;
    logic [SQ_W-1:0] sq;
  } mx_t;

  // Round half up from 32 to 16 fraction bits.
  function automatic mtx_t rnd16(input logic signed [37:0] v);
    logic signed [37:0] t;
    t = (v + 38'sd32768) >>> 16;
    return t[18:0];
  endfunction

endpackage

// ===== sv/cpe_sincos.sv =====
module cpe_sincos #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                en_i,
  input  logic signed [15:0]  angle_i,
  output cpe_pkg::trig_t      cos_o,
  output cpe_pkg::trig_t      sin_o
);

  localparam int N = CORDIC_STAGES;

  logic signed [32:0] x_r [N+1];
  logic signed [32:0] y_r [N+1];
  cpe_pkg::ang_t      z_r [N+1];
  logic               neg_r [N+1];
  cpe_pkg::trig_t     cos_r, sin_r;

  cpe_pkg::ang_t      z0;
  cpe_pkg::ang_t      zf;
  logic               negf;
  logic signed [32:0] xrnd, yrnd;
  cpe_pkg::trig_t     xs, ys;

  // Fold the angle into +-pi/2; the sign of the result flips.
  always_comb begin
    z0   = {{2{angle_i[15]}}, angle_i, 17'b0};
    zf   = z0;
    negf = 1'b0;
    if (z0 > cpe_pkg::ANG_HALF_PI) begin
      zf   = z0 - cpe_pkg::ANG_PI;
      negf = 1'b1;
    end else if (z0 < -cpe_pkg::ANG_HALF_PI) begin
      zf   = z0 + cpe_pkg::ANG_PI;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      x_r[0]   <= cpe_pkg::CORDIC_GAIN;
      y_r[0]   <= '0;
      z_r[0]   <= zf;
      neg_r[0] <= negf;
    end
  end

  // One rotation per stage.
  for (genvar k = 0; k < N; k++) begin : g_rot
    localparam cpe_pkg::ang_t STEP = $signed({4'b0, cpe_pkg::ATAN_TAB[k]});
    always_ff @(posedge clk) begin
      if (en_i) begin
        if (!z_r[k][34]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - STEP;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + STEP;
        end
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // Round to 16 fraction bits and apply the fold sign.
  always_comb begin
    xrnd = (x_r[N] + 33'sd8192) >>> 14;
    yrnd = (y_r[N] + 33'sd8192) >>> 14;
    xs   = xrnd[17:0];
    ys   = yrnd[17:0];
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      cos_r <= neg_r[N] ? -xs : xs;
      sin_r <= neg_r[N] ? -ys : ys;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== sv/cpe_matrix.sv =====
module cpe_matrix (
  input  logic            clk,
  input  logic            en_i,
  input  cpe_pkg::trig_t  c_i,
  input  cpe_pkg::trig_t  s_i,
  input  cpe_pkg::trig_t  cp_i,
  input  cpe_pkg::trig_t  sp_i,
  input  cpe_pkg::trig_t  ct_i,
  input  cpe_pkg::trig_t  st_i,
  output cpe_pkg::mx_t    mx_o
);

  // Stage 1 products.
  logic signed [35:0] ctcp_m_r, stcp_m_r, stsp_m_r, csp_m_r, ssp_m_r;
  cpe_pkg::trig_t     c1_r, s1_r, ct1_r;
  // Stage 2 rounded terms.
  cpe_pkg::mtx_t      ctcp_r, r20n2_r, r21_2_r, r22_2_r;
  cpe_pkg::trig_t     c2_r, s2_r;
  logic signed [35:0] csp2_r, ssp2_r;
  // Stage 3 second-level products.
  logic signed [36:0] m1_r, m2_r;
  logic signed [37:0] sq21_r, sq22_r;
  logic signed [35:0] csp3_r, ssp3_r;
  cpe_pkg::mtx_t      r20n3_r, r21_3_r, r22_3_r;
  // Stage 4 result.
  cpe_pkg::mx_t       mx_r;

  logic signed [37:0] sqsum;

  always_ff @(posedge clk) begin
    if (en_i) begin
      ctcp_m_r <= ct_i * cp_i;
      stcp_m_r <= st_i * cp_i;
      stsp_m_r <= st_i * sp_i;
      csp_m_r  <= c_i * sp_i;
      ssp_m_r  <= s_i * sp_i;
      c1_r     <= c_i;
      s1_r     <= s_i;
      ct1_r    <= ct_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      ctcp_r  <= cpe_pkg::rnd16(38'(ctcp_m_r));
      r20n2_r <= cpe_pkg::rnd16(38'(stcp_m_r));
      r22_2_r <= -cpe_pkg::rnd16(38'(stsp_m_r));
      r21_2_r <= -cpe_pkg::mtx_t'(ct1_r);
      c2_r    <= c1_r;
      s2_r    <= s1_r;
      csp2_r  <= csp_m_r;
      ssp2_r  <= ssp_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      m1_r    <= s2_r * ctcp_r;
      m2_r    <= c2_r * ctcp_r;
      sq21_r  <= r21_2_r * r21_2_r;
      sq22_r  <= r22_2_r * r22_2_r;
      csp3_r  <= csp2_r;
      ssp3_r  <= ssp2_r;
      r20n3_r <= r20n2_r;
      r21_3_r <= r21_2_r;
      r22_3_r <= r22_2_r;
    end
  end

  assign sqsum = sq21_r + sq22_r;

  // Final entries and the sum of squares for the pitch magnitude.
  always_ff @(posedge clk) begin
    if (en_i) begin
      mx_r.rot.r00  <= cpe_pkg::rnd16(38'(m1_r) - 38'(csp3_r));
      mx_r.rot.r10  <= cpe_pkg::rnd16(-(38'(ssp3_r) + 38'(m2_r)));
      mx_r.rot.r20n <= r20n3_r;
      mx_r.rot.r21  <= r21_3_r;
      mx_r.rot.r22  <= r22_3_r;
      mx_r.sq       <= sqsum[cpe_pkg::SQ_W-1:0];
    end
  end

  assign mx_o = mx_r;

endmodule

// ===== sv/cpe_isqrt.sv =====
module cpe_isqrt (
  input  logic                         clk,
  input  logic                         en_i,
  input  logic [cpe_pkg::SQ_W-1:0]     sq_i,
  output logic [cpe_pkg::ROOT_W-1:0]   root_o
);

  localparam int W = cpe_pkg::SQ_W;
  localparam int S = cpe_pkg::SQ_STEPS;

  logic [W-1:0] v_r   [S];
  logic [W-1:0] res_r [S];

  // One root digit per stage, bit moving down by two places each time.
  for (genvar k = 0; k < S; k++) begin : g_dig
    localparam logic [W-1:0] BIT = W'(1) << (2 * (S - 1 - k));
    logic [W-1:0] vi, ri, trial;
    if (k == 0) begin : g_first
      assign vi = sq_i;
      assign ri = '0;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign ri = res_r[k-1];
    end
    assign trial = ri + BIT;
    always_ff @(posedge clk) begin
      if (en_i) begin
        if (vi >= trial) begin
          v_r[k]   <= vi - trial;
          res_r[k] <= (ri >> 1) + BIT;
        end else begin
          v_r[k]   <= vi;
          res_r[k] <= ri >> 1;
        end
      end
    end
  end

  assign root_o = res_r[S-1][cpe_pkg::ROOT_W-1:0];

endmodule

// ===== sv/cpe_atan2.sv =====
module cpe_atan2 #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic           clk,
  input  logic           en_i,
  input  cpe_pkg::mtx_t  y_i,
  input  cpe_pkg::mtx_t  x_i,
  output cpe_pkg::mtx_t  ang_o
);

  localparam int N = CORDIC_STAGES;

  logic signed [35:0] x_r [N+1];
  logic signed [35:0] y_r [N+1];
  cpe_pkg::ang_t      z_r [N+1];
  logic               zero_r [N+1];
  cpe_pkg::mtx_t      ang_r;

  logic signed [35:0] x0, y0;
  cpe_pkg::ang_t      zrnd;

  assign x0 = {{3{x_i[18]}}, x_i, 14'b0};
  assign y0 = {{3{y_i[18]}}, y_i, 14'b0};

  // Left half plane: start from +-pi with the vector turned around.
  always_ff @(posedge clk) begin
    if (en_i) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[18]) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        z_r[0] <= y_i[18] ? -cpe_pkg::ANG_PI : cpe_pkg::ANG_PI;
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        z_r[0] <= '0;
      end
    end
  end

  // One vectoring step per stage.
  for (genvar k = 0; k < N; k++) begin : g_vec
    localparam cpe_pkg::ang_t STEP = $signed({4'b0, cpe_pkg::ATAN_TAB[k]});
    always_ff @(posedge clk) begin
      if (en_i) begin
        if (!y_r[k][35]) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + STEP;
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - STEP;
        end
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  // Round to Q3.13.
  assign zrnd = (z_r[N] + 35'sd65536) >>> 17;

  always_ff @(posedge clk) begin
    if (en_i) begin
      ang_r <= zero_r[N] ? '0 : zrnd[18:0];
    end
  end

  assign ang_o = ang_r;

endmodule

// ===== sv/camera_pose_from_euler_angles.sv =====
// Camera pose from a vehicle sample: position minus the configured start point
// (saturating) and the roll, pitch and yaw of vehicle yaw * camera tilt/pan *
// world alignment, all in Q3.13 radians. The datapath is one pipeline: three
// rotation CORDICs, four multiply stages building the matrix, an 18-stage
// digit-by-digit square root and three vectoring CORDICs, each CORDIC taking
// CORDIC_STAGES + 2 stages. A request is accepted every cycle unless the output
// buffer is full. A two-entry output buffer lets requests enter while a result
// waits; the whole pipeline holds only when both entries are full. Start
// registers are to be written through the cfg port only while the block is
// idle; the block itself does not enforce this.
module camera_pose_from_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pos_east[31:0], pos_north[63:32], heading[79:64], pan_angle[95:80],
  // tilt_angle[111:96]
  input  logic [111:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // rel_east[31:0], rel_north[63:32], roll[79:64], pitch[94:80], yaw[110:95],
  // zero[111]
  output logic [111:0]  out_tdata,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int SC_LAT = CORDIC_STAGES + 2;
  localparam int MX_LAT = 4;
  localparam int SQ_LAT = cpe_pkg::SQ_STEPS;
  localparam int AT_LAT = CORDIC_STAGES + 2;
  localparam int TOT    = SC_LAT + MX_LAT + SQ_LAT + AT_LAT;

  logic signed [31:0] start_east_r, start_north_r;
  logic               v_r   [TOT];
  logic [63:0]        pos_r [TOT];
  cpe_pkg::rot_t      rot_r [SQ_LAT];
  logic               out_v_r, skid_v_r;
  logic [111:0]       out_d_r, skid_d_r;

  logic               en;
  cpe_pkg::trig_t     c, s, cp, sp, ct, st;
  cpe_pkg::mx_t       mx;
  logic [cpe_pkg::ROOT_W-1:0] mag;
  cpe_pkg::mtx_t      roll_z, pitch_z, yaw_z;
  cpe_pkg::rot_t      rot_d;
  logic [111:0]       res_d;
  logic               push, pop;

  // The pipeline moves unless the output buffer is full.
  assign en        = !skid_v_r;
  assign in_tready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_east_r  <= '0;
      start_north_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cpe_pkg::REG_START_EAST:  start_east_r  <= cfg_wdata;
        cpe_pkg::REG_START_NORTH: start_north_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits and positions travel alongside the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < TOT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r[0] <= in_tdata[63:0];
      for (int i = 1; i < TOT; i++) pos_r[i] <= pos_r[i-1];
    end
  end

  // Sine and cosine of the three input angles.
  cpe_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_head (
    .clk(clk), .en_i(en), .angle_i(in_tdata[79:64]), .cos_o(c), .sin_o(s)
  );
  cpe_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_pan (
    .clk(clk), .en_i(en), .angle_i(in_tdata[95:80]), .cos_o(cp), .sin_o(sp)
  );
  cpe_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_tilt (
    .clk(clk), .en_i(en), .angle_i(in_tdata[111:96]), .cos_o(ct), .sin_o(st)
  );

  cpe_matrix u_mx (
    .clk(clk), .en_i(en), .c_i(c), .s_i(s), .cp_i(cp), .sp_i(sp),
    .ct_i(ct), .st_i(st), .mx_o(mx)
  );

  cpe_isqrt u_sq (
    .clk(clk), .en_i(en), .sq_i(mx.sq), .root_o(mag)
  );

  // Matrix entries wait for the root.
  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= mx.rot;
      for (int i = 1; i < SQ_LAT; i++) rot_r[i] <= rot_r[i-1];
    end
  end

  assign rot_d = rot_r[SQ_LAT-1];

  cpe_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_roll (
    .clk(clk), .en_i(en), .y_i(rot_d.r21), .x_i(rot_d.r22), .ang_o(roll_z)
  );
  cpe_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_pitch (
    .clk(clk), .en_i(en), .y_i(rot_d.r20n), .x_i($signed({1'b0, mag})),
    .ang_o(pitch_z)
  );
  cpe_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_yaw (
    .clk(clk), .en_i(en), .y_i(rot_d.r10), .x_i(rot_d.r00), .ang_o(yaw_z)
  );

  // Saturating subtract and angle clamps for the result.
  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    if (d[32] != d[31]) return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return d[31:0];
  endfunction

  function automatic cpe_pkg::mtx_t clamp(input cpe_pkg::mtx_t v, input cpe_pkg::mtx_t lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  always_comb begin
    cpe_pkg::mtx_t r, p, y;
    r = clamp(roll_z, 19'sd25736);
    p = clamp(pitch_z, 19'sd12868);
    y = clamp(yaw_z, 19'sd25736);
    res_d = {1'b0, y[15:0], p[14:0], r[15:0],
             sat_sub(pos_r[TOT-1][63:32], start_north_r),
             sat_sub(pos_r[TOT-1][31:0], start_east_r)};
  end

  // Output register with a skid entry behind it.
  assign push = en && v_r[TOT-1];
  assign pop  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) out_d_r <= skid_d_r;
    end else if (push) begin
      if (out_v_r && !pop) skid_d_r <= res_d;
      else                 out_d_r  <= res_d;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
